// ----- design/emadc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package emadc_pkg;

  localparam int CODE_W    = 16;
  localparam int CHARGE_W  = 32;
  localparam int CHG_OUT_W = 31;
  localparam int STEP_W    = 15;
  localparam int MAN_W     = 4;
  localparam int RNG_W     = 3;
  localparam int MAN_MAX   = 12;
  localparam int RNG_MAX   = 4;
  localparam int MAN_HI    = (CODE_W - 1 < MAN_MAX) ? (CODE_W - 1) : MAN_MAX;

  localparam logic [MAN_W-1:0] MAN_RST = 4'd8;
  localparam logic [RNG_W-1:0] RNG_RST = 3'd4;

  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_DECODE = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_MANTISSA_BITS = 1'b0,
    REG_RANGE_BITS    = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [MAN_W-1:0] man;
    logic [RNG_W-1:0] rng;
  } cfg_t;

endpackage
`default_nettype wire

// ----- design/emadc_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none
module emadc_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        wr_en,
  input  wire emadc_pkg::reg_idx_t         wr_idx,
  input  wire logic [emadc_pkg::MAN_W-1:0] wr_data,
  output emadc_pkg::cfg_t                  cfg
);

  logic [emadc_pkg::MAN_W-1:0] mantissa_bits_r, mantissa_bits_nxt;
  logic [emadc_pkg::RNG_W-1:0] range_bits_r, range_bits_nxt;
  logic [emadc_pkg::MAN_W:0]   rng_room;
  logic [emadc_pkg::MAN_W-1:0] man_eff;
  logic [emadc_pkg::RNG_W-1:0] rng_eff;

  always_comb begin
    mantissa_bits_nxt = mantissa_bits_r;
    range_bits_nxt    = range_bits_r;
    if (wr_en) begin
      unique case (wr_idx)
        emadc_pkg::REG_MANTISSA_BITS: mantissa_bits_nxt = wr_data;
        emadc_pkg::REG_RANGE_BITS:    range_bits_nxt    = wr_data[emadc_pkg::RNG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mantissa_bits_r <= emadc_pkg::MAN_RST;
      range_bits_r    <= emadc_pkg::RNG_RST;
    end else begin
      mantissa_bits_r <= mantissa_bits_nxt;
      range_bits_r    <= range_bits_nxt;
    end
  end

  // clamp M, then clamp E against the code bits left over
  always_comb begin
    if (mantissa_bits_r == '0) begin
      man_eff = 4'd1;
    end else if (32'(mantissa_bits_r) > emadc_pkg::MAN_HI) begin
      man_eff = 4'(emadc_pkg::MAN_HI);
    end else begin
      man_eff = mantissa_bits_r;
    end
    rng_room = 5'(emadc_pkg::CODE_W) - {1'b0, man_eff};
    if (range_bits_r == '0) begin
      rng_eff = 3'd1;
    end else if (32'(range_bits_r) > emadc_pkg::RNG_MAX) begin
      rng_eff = 3'(emadc_pkg::RNG_MAX);
    end else begin
      rng_eff = range_bits_r;
    end
    if ({2'b0, rng_eff} > rng_room) begin
      rng_eff = rng_room[emadc_pkg::RNG_W-1:0];
    end
  end

  assign cfg.man = man_eff;
  assign cfg.rng = rng_eff;

endmodule
`default_nettype wire

// ----- design/emadc_enc.sv -----
`timescale 1ns / 1ps
`default_nettype none
module emadc_enc (
  input  wire emadc_pkg::cfg_t                cfg,
  input  wire logic [emadc_pkg::CHARGE_W-1:0] charge,
  output logic [emadc_pkg::CODE_W-1:0]        code,
  output logic                                sat
);

  logic [30:0] mag;
  logic        neg;
  logic [4:0]  lead;
  logic [5:0]  shift;
  logic [4:0]  top;
  logic        lin;
  logic        over;
  logic [30:0] shifted;
  logic [15:0] rng_part;
  logic [15:0] norm_code;
  logic [16:0] ones;

  assign mag = charge[30:0];
  assign neg = charge[emadc_pkg::CHARGE_W-1];

  // leading-one position
  always_comb begin
    lead = '0;
    for (int i = 0; i < 31; i++) begin
      if (mag[i]) lead = 5'(i);
    end
  end

  assign shift     = {1'b0, lead} - {2'b0, cfg.man};
  assign top       = 5'd1 << cfg.rng;
  assign lin       = (mag >> ({1'b0, cfg.man} + 5'd1)) == 31'd0;
  assign over      = ({1'b0, shift} + 7'd1) >= {2'b0, top};
  assign shifted   = mag >> shift;
  assign rng_part  = {12'd0, shift[3:0]} << cfg.man;
  assign norm_code = rng_part + {3'd0, shifted[12:0]};
  assign ones      = (17'd1 << ({1'b0, cfg.man} + {2'b0, cfg.rng})) - 17'd1;

  always_comb begin
    code = '0;
    sat  = 1'b0;
    if (neg) begin
      code = '0;
    end else if (lin) begin
      code = {3'd0, mag[12:0]};
    end else if (over) begin
      code = ones[15:0];
      sat  = 1'b1;
    end else begin
      code = norm_code;
    end
  end

endmodule
`default_nettype wire

// ----- design/emadc_dec.sv -----
`timescale 1ns / 1ps
`default_nettype none
module emadc_dec (
  input  wire emadc_pkg::cfg_t                 cfg,
  input  wire logic [emadc_pkg::CODE_W-1:0]    code,
  output logic [emadc_pkg::CHG_OUT_W-1:0]      charge,
  output logic [emadc_pkg::STEP_W-1:0]         step
);

  logic [16:0] code_mask;
  logic [15:0] code_m;
  logic [15:0] rng_full;
  logic [3:0]  rng;
  logic [3:0]  rng_m1;
  logic [12:0] man_mask;
  logic [11:0] man;
  logic [12:0] man_full;

  assign code_mask = (17'd1 << ({1'b0, cfg.man} + {2'b0, cfg.rng})) - 17'd1;
  assign code_m    = code & code_mask[15:0];
  assign rng_full  = code_m >> cfg.man;
  assign rng       = rng_full[3:0];
  assign rng_m1    = rng - 4'd1;
  assign man_mask  = (13'd1 << cfg.man) - 13'd1;
  assign man       = code_m[11:0] & man_mask[11:0];
  assign man_full  = {1'b0, man} | (13'd1 << cfg.man);

  always_comb begin
    if (rng == 4'd0) begin
      charge = {19'd0, man};
      step   = 15'd1;
    end else begin
      charge = {18'd0, man_full} << rng_m1;
      step   = 15'd1 << rng_m1;
    end
  end

endmodule
`default_nettype wire

// ----- design/exp_mantissa_adc_codec_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Exponent-plus-mantissa ADC codec. A request is taken on every cycle with
// start high (busy stays low) and its result appears on the out_ ports for
// one cycle, flagged by out_strobe, after one input register, one pass of
// leading-one detect and shifts, and one result register. The receiver
// cannot stall, so it must take each result in the cycle it is shown. Write
// mantissa_bits (index 0) and range_bits (index 1) only with no request in
// flight; cfg_ready is always high.
module exp_mantissa_adc_codec_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 in_command,
  input  wire logic signed [emadc_pkg::CHARGE_W-1:0] in_charge_in,
  input  wire logic [emadc_pkg::CODE_W-1:0]         in_code_in,
  output logic                                      out_strobe,
  output logic [emadc_pkg::CODE_W-1:0]              out_code_out,
  output logic                                      out_saturated,
  output logic [emadc_pkg::CHG_OUT_W-1:0]           out_charge_out,
  output logic [emadc_pkg::STEP_W-1:0]              out_step_width,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic                                 cfg_index,
  input  wire logic [emadc_pkg::MAN_W-1:0]          cfg_wdata
);

  emadc_pkg::cfg_t                   cfg;
  logic                              accept;
  logic                              in_vld_r;
  emadc_pkg::cmd_t                   cmd_r;
  logic [emadc_pkg::CHARGE_W-1:0]    charge_r;
  logic [emadc_pkg::CODE_W-1:0]      code_r;
  logic [emadc_pkg::CODE_W-1:0]      enc_code;
  logic                              enc_sat;
  logic [emadc_pkg::CHG_OUT_W-1:0]   dec_charge;
  logic [emadc_pkg::STEP_W-1:0]      dec_step;
  logic                              out_vld_r;
  logic [emadc_pkg::CODE_W-1:0]      code_out_r, code_out_nxt;
  logic                              sat_r, sat_nxt;
  logic [emadc_pkg::CHG_OUT_W-1:0]   charge_out_r, charge_out_nxt;
  logic [emadc_pkg::STEP_W-1:0]      step_r, step_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  emadc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_idx  (emadc_pkg::reg_idx_t'(cfg_index)),
    .wr_data (cfg_wdata),
    .cfg     (cfg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= accept;
      out_vld_r <= in_vld_r;
    end
  end

  // hold the request payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= emadc_pkg::cmd_t'(in_command);
      charge_r <= in_charge_in;
      code_r   <= in_code_in;
    end
  end

  emadc_enc u_enc (
    .cfg    (cfg),
    .charge (charge_r),
    .code   (enc_code),
    .sat    (enc_sat)
  );

  emadc_dec u_dec (
    .cfg    (cfg),
    .code   (code_r),
    .charge (dec_charge),
    .step   (dec_step)
  );

  always_comb begin
    code_out_nxt   = '0;
    sat_nxt        = 1'b0;
    charge_out_nxt = '0;
    step_nxt       = '0;
    unique case (cmd_r)
      emadc_pkg::CMD_ENCODE: begin
        code_out_nxt = enc_code;
        sat_nxt      = enc_sat;
      end
      emadc_pkg::CMD_DECODE: begin
        charge_out_nxt = dec_charge;
        step_nxt       = dec_step;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      code_out_r   <= code_out_nxt;
      sat_r        <= sat_nxt;
      charge_out_r <= charge_out_nxt;
      step_r       <= step_nxt;
    end
  end

  assign out_strobe     = out_vld_r;
  assign out_code_out   = code_out_r;
  assign out_saturated  = sat_r;
  assign out_charge_out = charge_out_r;
  assign out_step_width = step_r;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_strobe)
    else $error("request did not produce a result two cycles later");

  a_sat_encode_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_saturated) |-> (out_charge_out == '0 && out_step_width == '0))
    else $error("saturated flag on a decode result");

  a_step_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_step_width != '0) |->
      ($onehot(out_step_width) && out_code_out == '0 && !out_saturated))
    else $error("decode step width malformed or encode fields set");
`endif

endmodule
`default_nettype wire
